// ----- rtl/wireworld_generation_stencil_top_macros.svh -----
// assertion macros shared by the wireworld stencil checker
`ifndef WIREWORLD_GENERATION_STENCIL_TOP_MACROS_SVH
`define WIREWORLD_GENERATION_STENCIL_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define WWGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define WWGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define WWGS_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wwgs_pkg.sv -----
// types and constants for the wireworld generation stencil
`timescale 1ns / 1ps

package wwgs_pkg;

  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_HEAD  = 2'd1,
    CELL_TAIL  = 2'd2,
    CELL_COND  = 2'd3
  } cell_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int GW_W       = 7;
  localparam int ROW_W      = 13;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  typedef struct packed {
    logic [1:0] cell_state;
    logic       flush;
  } cell_word_t;

  typedef struct packed {
    logic [1:0] next_state;
    logic       frame_end;
  } res_word_t;

  // one line buffer entry: two rows back and one row back
  typedef struct packed {
    cell_t upper;
    cell_t middle;
  } line_pair_t;

  // one window column, top to bottom
  typedef struct packed {
    cell_t top;
    cell_t mid;
    cell_t bot;
  } column_t;

  localparam column_t EMPTY_COLUMN = '{top: CELL_EMPTY, mid: CELL_EMPTY, bot: CELL_EMPTY};

endpackage

// ----- rtl/wwgs_cell.sv -----
// one line buffer cell of the shift chain
`timescale 1ns / 1ps

module wwgs_cell (
  input  logic                clk,
  input  logic                shift,
  input  logic                load,
  input  wwgs_pkg::line_pair_t ins,
  input  wwgs_pkg::line_pair_t nbr,
  output wwgs_pkg::line_pair_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= load ? ins : nbr;
    end
  end

endmodule

// ----- rtl/wwgs_window.sv -----
// 3x3 window and wireworld next-state rule
`timescale 1ns / 1ps

module wwgs_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              shift,
  input  logic              row_start,
  input  wwgs_pkg::column_t col_in,
  output wwgs_pkg::cell_t   next_state
);

  wwgs_pkg::column_t left_col;
  wwgs_pkg::column_t centre_col;
  wwgs_pkg::column_t right_col;
  logic [7:0]        is_head;
  logic [3:0]        heads;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      left_col   <= wwgs_pkg::EMPTY_COLUMN;
      centre_col <= wwgs_pkg::EMPTY_COLUMN;
    end else if (shift) begin
      left_col   <= row_start ? wwgs_pkg::EMPTY_COLUMN : centre_col;
      centre_col <= col_in;
    end
  end

  // right column is off the grid when the centre is the last cell of a row
  assign right_col = row_start ? wwgs_pkg::EMPTY_COLUMN : col_in;

  assign is_head[0] = (left_col.top == wwgs_pkg::CELL_HEAD);
  assign is_head[1] = (left_col.mid == wwgs_pkg::CELL_HEAD);
  assign is_head[2] = (left_col.bot == wwgs_pkg::CELL_HEAD);
  assign is_head[3] = (centre_col.top == wwgs_pkg::CELL_HEAD);
  assign is_head[4] = (centre_col.bot == wwgs_pkg::CELL_HEAD);
  assign is_head[5] = (right_col.top == wwgs_pkg::CELL_HEAD);
  assign is_head[6] = (right_col.mid == wwgs_pkg::CELL_HEAD);
  assign is_head[7] = (right_col.bot == wwgs_pkg::CELL_HEAD);

  always_comb begin
    heads = '0;
    for (int i = 0; i < 8; i++) begin
      heads = heads + 4'(is_head[i]);
    end
  end

  always_comb begin
    case (centre_col.mid)
      wwgs_pkg::CELL_HEAD: next_state = wwgs_pkg::CELL_TAIL;
      wwgs_pkg::CELL_TAIL: next_state = wwgs_pkg::CELL_COND;
      wwgs_pkg::CELL_COND: begin
        next_state = (heads == 4'd1 || heads == 4'd2) ? wwgs_pkg::CELL_HEAD
                                                      : wwgs_pkg::CELL_COND;
      end
      default: next_state = wwgs_pkg::CELL_EMPTY;
    endcase
  end

endmodule

// ----- rtl/wireworld_generation_stencil_top.sv -----
// top level of the wireworld generation stencil
//
// Cells of a frame enter on cell_valid/cell_ready/cell_word in raster order,
// grid_width words per row; results leave on res_valid/res_ready/res_word.
// Each accepted word shifts a chain of MAX_WIDTH line buffer cells and a 3x3
// window, so one word is taken per cycle while cell_ready is high, and after
// the first grid_width+1 words of a frame, which give no result, one result
// comes out per word: the result for a cell enters the output register, or the
// skid stage if that is still full, when the word grid_width+1 places later is
// accepted. End each frame with grid_width+1 flush words; the result for the
// last grid cell carries frame_end and the next word starts a new frame.
// Configuration goes in on cfg_we/cfg_index/cfg_data; the user must write it
// only while idle (the block does not enforce this); any write restarts the frame.
// Reset restores grid_width min(MAX_WIDTH, 64) and grid_height 64 and clears
// the counters, window and result stages; the line buffer needs no clearing.
// When the receiver stalls, one result waits in the output register and one
// more in a skid stage; cell_ready drops only when both are full.
`timescale 1ns / 1ps

module wireworld_generation_stencil_top #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wwgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wwgs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                cell_valid,
  output logic                                cell_ready,
  input  wwgs_pkg::cell_word_t                cell_word,
  output logic                                res_valid,
  input  logic                                res_ready,
  output wwgs_pkg::res_word_t                 res_word
);

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int RST_WIDTH = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;

  logic [COL_W-1:0]               last_col;
  logic [wwgs_pkg::ROW_W-1:0]     eff_height;
  logic [wwgs_pkg::ROW_W-1:0]     term_row;
  logic [COL_W-1:0]               col;
  logic [wwgs_pkg::ROW_W-1:0]     row;

  logic [wwgs_pkg::GW_W-1:0]      cfg_gw;
  logic [wwgs_pkg::ROW_W-1:0]     cfg_gh;
  logic [COL_W-1:0]               last_col_next;
  logic [wwgs_pkg::ROW_W-1:0]     eff_height_next;

  logic                           accept;
  logic                           row_start;
  logic                           at_last_col;
  logic                           emit;
  logic                           frame_done;
  logic                           push;
  logic                           pop;

  wwgs_pkg::column_t              col_in;
  wwgs_pkg::line_pair_t           chain_ins;
  wwgs_pkg::line_pair_t           chain_q   [MAX_WIDTH];
  wwgs_pkg::line_pair_t           chain_nbr [MAX_WIDTH];
  wwgs_pkg::cell_t                win_next;
  wwgs_pkg::res_word_t            new_res;

  wwgs_pkg::res_word_t            skid_word;
  logic                           skid_valid;

  // configuration decode with range clamping
  assign cfg_gw = cfg_data[wwgs_pkg::GW_W-1:0];
  assign cfg_gh = cfg_data[wwgs_pkg::ROW_W-1:0];

  always_comb begin
    if (cfg_gw == '0) begin
      last_col_next = '0;
    end else if (int'(cfg_gw) > MAX_WIDTH) begin
      last_col_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_next = COL_W'(cfg_gw - 7'd1);
    end
  end

  always_comb begin
    if (cfg_gh == '0) begin
      eff_height_next = wwgs_pkg::ROW_W'(1);
    end else if (int'(cfg_gh) > wwgs_pkg::MAX_HEIGHT) begin
      eff_height_next = wwgs_pkg::ROW_W'(wwgs_pkg::MAX_HEIGHT);
    end else begin
      eff_height_next = cfg_gh;
    end
  end

  assign accept      = cell_valid && cell_ready;
  assign row_start   = (col == '0);
  assign at_last_col = (col == last_col);
  assign emit        = (row >= wwgs_pkg::ROW_W'(2)) ||
                       (row == wwgs_pkg::ROW_W'(1) && !row_start);
  assign frame_done  = emit && (row == term_row) && row_start;

  // new window column, rows above or below the grid read as empty
  assign col_in.top = (row >= wwgs_pkg::ROW_W'(2)) ? chain_q[0].upper
                                                  : wwgs_pkg::CELL_EMPTY;
  assign col_in.mid = (row >= wwgs_pkg::ROW_W'(1)) ? chain_q[0].middle
                                                  : wwgs_pkg::CELL_EMPTY;
  assign col_in.bot = (row < eff_height && !cell_word.flush)
                      ? wwgs_pkg::cell_t'(cell_word.cell_state)
                      : wwgs_pkg::CELL_EMPTY;

  assign chain_ins.upper  = col_in.mid;
  assign chain_ins.middle = col_in.bot;

  // line buffer chain, words enter at the last column in use and leave at cell 0
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_chain
    if (i == MAX_WIDTH - 1) begin : g_end
      assign chain_nbr[i] = chain_ins;
    end else begin : g_mid
      assign chain_nbr[i] = chain_q[i+1];
    end

    wwgs_cell u_cell (
      .clk   (clk),
      .shift (accept),
      .load  (last_col == COL_W'(i)),
      .ins   (chain_ins),
      .nbr   (chain_nbr[i]),
      .q     (chain_q[i])
    );
  end

  wwgs_window u_window (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_we || (accept && frame_done)),
    .shift      (accept),
    .row_start  (row_start),
    .col_in     (col_in),
    .next_state (win_next)
  );

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      last_col   <= COL_W'(RST_WIDTH - 1);
      eff_height <= wwgs_pkg::ROW_W'(64);
      term_row   <= wwgs_pkg::ROW_W'(65);
      col        <= '0;
      row        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wwgs_pkg::REG_GRID_WIDTH: begin
          last_col <= last_col_next;
        end
        wwgs_pkg::REG_GRID_HEIGHT: begin
          eff_height <= eff_height_next;
          term_row   <= eff_height_next + wwgs_pkg::ROW_W'(1);
        end
        default: begin
        end
      endcase
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (frame_done) begin
        col <= '0;
        row <= '0;
      end else if (at_last_col) begin
        col <= '0;
        row <= row + wwgs_pkg::ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // output register plus skid stage
  assign new_res.next_state = 2'(win_next);
  assign new_res.frame_end  = frame_done;
  assign push               = accept && emit;
  assign pop                = res_valid && res_ready;
  assign cell_ready         = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!res_valid || pop) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        res_word <= skid_word;
      end
    end else if (push) begin
      if (!res_valid || pop) begin
        res_word <= new_res;
      end else begin
        skid_word <= new_res;
      end
    end
  end

endmodule

// ----- rtl/wwgs_checker.sv -----
// port-level checker for the wireworld stencil, bound to the top level
`timescale 1ns / 1ps
`include "wireworld_generation_stencil_top_macros.svh"

module wwgs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cell_valid,
  input logic                            cell_ready,
  input wwgs_pkg::cell_word_t            cell_word,
  input logic                            res_valid,
  input logic                            res_ready,
  input wwgs_pkg::res_word_t             res_word
);

  `WWGS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word), "result word changed while stalled")

  `WWGS_ASSERT_NEXT_RST(a_reset_empty, rst, !res_valid, "result valid right after reset")

  `WWGS_ASSERT_NOW(a_rise_needs_word, $rose(res_valid), $past(cell_valid && cell_ready), "result appeared without an accepted cell word")

  `WWGS_ASSERT_NOW(a_stall_needs_result, !cell_ready, res_valid, "input stalled with no result waiting")

  `WWGS_ASSERT_NEXT(a_no_stall_when_drained, cell_ready && res_ready, cell_ready, "input stalled while results drain every cycle")

endmodule

bind wireworld_generation_stencil_top wwgs_checker u_wwgs_checker (.*);
